// ----- rtl/pls_pkg.sv -----
// Package for the positional list store: sizes, codes and the cell control struct.
`default_nettype none
package pls_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 5;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    ActInsPos = 3'd0,
    ActInsEnd = 3'd1,
    ActRemPos = 3'd2,
    ActRemEnd = 3'd3,
    ActRead   = 3'd4,
    ActFind   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadPos = 2'd1,
    StEmpty  = 2'd2,
    StFull   = 2'd3
  } status_e;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdxW-1:0] pos;
    logic [ValW-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// Top level of the positional list store: decode, row of slot cells, result register.
// The result is registered on the output register in the cycle after the input transfer.
// Throughput: one item per cycle while the output side takes results; every cell shifts, compares or holds in parallel.
// The output register frees the input side whenever the result is taken.
// Reset clears the element count and the output valid; slot contents are not cleared.
`default_nettype none
module positional_list_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // item_value[31:0], position[36:32], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // action[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // out_value[31:0], count_now[36:32], zero pad
  output logic      [2:0]  m_axis_tuser   // found[0], status[2:1]
);

  localparam int unsigned N = pls_pkg::Capacity;

  logic [pls_pkg::CntW-1:0] count_q, count_d;
  logic                     out_valid_q;
  logic [pls_pkg::ValW-1:0] out_value_q, out_value_d;
  logic                     found_q, found_d;
  pls_pkg::status_e         status_q, status_d;
  logic [pls_pkg::CntW-1:0] cnt_out_q;

  logic                     accept;
  pls_pkg::action_e         act;
  logic [pls_pkg::ValW-1:0] in_value;
  logic [pls_pkg::CmpW-1:0] pos_ext, cnt_ext, eff_pos;
  logic                     empty, full, do_ins, do_rem;
  pls_pkg::cell_ctrl_t      ctrl;

  logic [pls_pkg::ValW-1:0] vals  [N];
  logic [N-1:0]             match;
  logic [N-1:0]             live;
  logic                     hit;
  logic [pls_pkg::ValW-1:0] sel_value;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign act      = pls_pkg::action_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[31:0];
  assign pos_ext  = pls_pkg::CmpW'(s_axis_tdata[36:32]);
  assign cnt_ext  = pls_pkg::CmpW'(count_q);
  assign empty    = count_q == '0;
  assign full     = count_q == pls_pkg::CntW'(N);

  always_comb begin
    unique case (act)
      pls_pkg::ActInsEnd: eff_pos = cnt_ext;
      pls_pkg::ActRemEnd: eff_pos = cnt_ext - pls_pkg::CmpW'(1);
      default:            eff_pos = pos_ext;
    endcase
  end

  assign sel_value = vals[pls_pkg::IdxW'(eff_pos)];

  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    status_d    = pls_pkg::StOk;
    out_value_d = '0;
    found_d     = 1'b0;
    unique case (act)
      pls_pkg::ActInsPos: begin
        if (pos_ext > cnt_ext) begin
          status_d = pls_pkg::StBadPos;
        end else if (full) begin
          status_d = pls_pkg::StFull;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::ActInsEnd: begin
        if (full) begin
          status_d = pls_pkg::StFull;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::ActRemPos, pls_pkg::ActRead: begin
        if (empty) begin
          status_d = pls_pkg::StEmpty;
        end else if (pos_ext >= cnt_ext) begin
          status_d = pls_pkg::StBadPos;
        end else begin
          do_rem      = act == pls_pkg::ActRemPos;
          out_value_d = sel_value;
        end
      end
      pls_pkg::ActRemEnd: begin
        if (empty) begin
          status_d = pls_pkg::StEmpty;
        end else begin
          do_rem      = 1'b1;
          out_value_d = sel_value;
        end
      end
      pls_pkg::ActFind: begin
        found_d = hit;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + pls_pkg::CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - pls_pkg::CntW'(1);
    end
  end

  assign ctrl.ins   = accept && do_ins;
  assign ctrl.rem   = accept && do_rem;
  assign ctrl.pos   = pls_pkg::IdxW'(eff_pos);
  assign ctrl.value = in_value;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [pls_pkg::ValW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = in_value;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    pls_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (pls_pkg::IdxW'(i)),
      .ctrl_i     (ctrl),
      .left_i     (left_v),
      .right_i    (right_v),
      .value_o    (vals[i]),
      .match_o    (match[i])
    );

    assign live[i] = pls_pkg::CntW'(i) < count_q;
  end

  assign hit = |(match & live);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      found_q     <= found_d;
      status_q    <= status_d;
      cnt_out_q   <= count_d;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, pls_pkg::CntOutW'(cnt_out_q), out_value_q};
  assign m_axis_tuser  = {status_q, found_q};

endmodule
`default_nettype wire

// ----- rtl/pls_cell.sv -----
// One slot of the list: shifts towards either neighbour and compares its value.
`default_nettype none
module pls_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pls_pkg::IdxW-1:0]      cell_idx_i,
  input  wire pls_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [pls_pkg::ValW-1:0]      left_i,
  input  wire logic [pls_pkg::ValW-1:0]      right_i,
  output logic      [pls_pkg::ValW-1:0]      value_o,
  output logic                               match_o
);

  logic [pls_pkg::ValW-1:0] value_q, value_d;
  logic                     above, at;

  assign above = cell_idx_i > ctrl_i.pos;
  assign at    = cell_idx_i == ctrl_i.pos;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (above) begin
        value_d = left_i;
      end else if (at) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem && (above || at)) begin
      value_d = right_i;
    end
  end

  // slot contents are undefined until written; the reset input only gates the match output
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == ctrl_i.value) && rst_ni;

endmodule
`default_nettype wire
